// ----- rtl/aeskt_pkg.sv -----
// ----------------------------------------------------------------------------
// aeskt_pkg: shared types, tables and round functions
// AES-256 sbox, xtime and byte-level helpers for the key transform.
// ----------------------------------------------------------------------------
`default_nettype none

package aeskt_pkg;

	localparam int unsigned NumRounds  = 14;
	localparam int unsigned RoundKeyW  = 4;
	localparam int unsigned BlockW     = 128;
	localparam int unsigned WordW      = 64;
	localparam int unsigned CfgIdxW    = 3;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] RegKey0  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegKey1  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegKey2  = 3'd2;
	localparam logic [CfgIdxW-1:0] RegKey3  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegCount = 3'd4;

	typedef logic [BlockW-1:0]    block_t;
	typedef logic [RoundKeyW-1:0] rnd_t;

	// control from sequencer to round unit
	typedef struct packed {
		logic load;      // xor both halves with round key 0
		logic step;      // run one round on both halves
		logic last;      // final round: no column mix
	} rctl_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		case (a)
		8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
		8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
		8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
		8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
		8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
		8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
		8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
		8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
		8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
		8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
		8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
		8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
		8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
		8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
		8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
		8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
		8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
		8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
		8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
		8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
		8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
		8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
		8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
		8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
		8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
		8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
		8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
		8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
		8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
		8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
		8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
		8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
		8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
		8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
		8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
		8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
		8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
		8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
		8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
		8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
		8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
		8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
		8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
		8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
		8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
		8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
		8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
		8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
		8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
		8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
		8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
		8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
		8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
		8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
		8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
		8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
		8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
		8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
		8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
		8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
		8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
		8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
		8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
		8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
		default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a block, byte 0 in the top bits
	function automatic logic [7:0] get_byte(input block_t b, input int i);
		return b[BlockW-1-8*i -: 8];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// one AES round: sub bytes, shift rows, optional column mix, key add
	function automatic block_t aes_round(input block_t s, input block_t rk,
			input logic last);
		logic [7:0] n [16];
		logic [7:0] m [16];
		logic [7:0] a0, a1, a2, a3, al;
		block_t o;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				n[i+4*c] = sbox(get_byte(s, i + 4*((c+i) & 3)));
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			m[4*c]   = last ? a0 : (a0 ^ al ^ xtime(a0 ^ a1));
			m[4*c+1] = last ? a1 : (a1 ^ al ^ xtime(a1 ^ a2));
			m[4*c+2] = last ? a2 : (a2 ^ al ^ xtime(a2 ^ a3));
			m[4*c+3] = last ? a3 : (a3 ^ al ^ xtime(a3 ^ a0));
		end
		for (int i = 0; i < 16; i++) begin
			o[BlockW-1-8*i -: 8] = m[i] ^ get_byte(rk, i);
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/aeskt_keyexp.sv -----
// ----------------------------------------------------------------------------
// aeskt_keyexp: key schedule unit
// Expands the 256-bit key one 128-bit round key per cycle into a local
// memory; the round unit reads it back by index.
// ----------------------------------------------------------------------------
`default_nettype none

module aeskt_keyexp
	import aeskt_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [255:0]  key,
	input  wire logic          start,     // begin expansion
	output logic               done,      // high while the last round key is written
	input  wire rnd_t          rd_idx,
	output block_t             rd_key     // registered read data
);

	block_t rk_mem [NumRounds+1];
	logic [255:0] win_q;   // last two round keys, newest in low half
	rnd_t idx_q;
	logic busy_q;
	logic [7:0] rcon_q;
	logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
	logic odd;

	// next 128 bits of schedule from the sliding window
	always_comb begin
		odd = idx_q[0];
		w0 = win_q[255:224]; w1 = win_q[223:192];
		w2 = win_q[191:160]; w3 = win_q[159:128];
		if (!odd) begin
			t = sub_word({win_q[23:0], win_q[31:24]}) ^ {rcon_q, 24'h0};
		end else begin
			t = sub_word(win_q[31:0]);
		end
		n0 = w0 ^ t;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
	end

	// sequencer: index 0 and 1 come straight from the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			rcon_q <= 8'h01;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			rcon_q <= 8'h01;
		end else if (busy_q) begin
			if (idx_q == rnd_t'(NumRounds)) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + rnd_t'(1);
			if (idx_q >= rnd_t'(2) && !idx_q[0]) begin
				rcon_q <= xtime(rcon_q);
			end
		end
	end

	// window update and memory write
	always_ff @(posedge clk) begin
		if (start) begin
			win_q <= key;
		end else if (busy_q && idx_q >= rnd_t'(2)) begin
			win_q <= {win_q[127:0], n0, n1, n2, n3};
		end
		if (busy_q) begin
			if (idx_q == rnd_t'(0)) begin
				rk_mem[idx_q] <= win_q[255:128];
			end else if (idx_q == rnd_t'(1)) begin
				rk_mem[idx_q] <= win_q[127:0];
			end else begin
				rk_mem[idx_q] <= {n0, n1, n2, n3};
			end
		end
		rd_key <= rk_mem[rd_idx];
	end

	assign done = busy_q && (idx_q == rnd_t'(NumRounds));

endmodule

`default_nettype wire

// ----- rtl/aeskt_round.sv -----
// ----------------------------------------------------------------------------
// aeskt_round: shared round unit
// Holds both halves: copy inputs, add round key or one AES round on each.
// ----------------------------------------------------------------------------
`default_nettype none

module aeskt_round
	import aeskt_pkg::*;
(
	input  wire logic   clk,
	input  wire rctl_t  ctl,
	input  wire block_t rk,
	input  wire block_t in_l,
	input  wire block_t in_r,
	input  wire logic   copy,      // take plaintexts without key add
	output block_t      left_q,
	output block_t      right_q
);

	// state registers of the two halves
	always_ff @(posedge clk) begin
		if (copy) begin
			left_q  <= in_l;
			right_q <= in_r;
		end else if (ctl.load) begin
			left_q  <= left_q ^ rk;
			right_q <= right_q ^ rk;
		end else if (ctl.step) begin
			left_q  <= aes_round(left_q, rk, ctl.last);
			right_q <= aes_round(right_q, rk, ctl.last);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/iterated_aes256_key_transform_top.sv -----
// Sequence: key expansion, then per configured encryption one key add and
//   14 rounds, both halves in parallel through one shared round unit (15 key
//   reads per encryption from the round key memory).
// Flow: one request at a time; not ready until the result has been taken.
// Reset: arst_n asynchronous active low clears control and config registers.
// ----------------------------------------------------------------------------
// iterated_aes256_key_transform_top: iterated AES-256 block transform
// Expands the key, then encrypts each 16-byte half count_q times.
// ----------------------------------------------------------------------------
`default_nettype none

module iterated_aes256_key_transform_top
	import aeskt_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// left_high, left_low, right_high, right_low
	input  wire logic [255:0]  s_axis_tdata,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// out_left_high, out_left_low, out_right_high, out_right_low
	output logic [255:0]       m_axis_tdata,
	input  wire logic          cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_idx,
	input  wire logic [WordW-1:0]   cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_KEY  = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_RND  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [WordW-1:0] key0_q, key1_q, key2_q, key3_q, count_q, iter_q;
	rnd_t rnd_q;
	logic kdone;
	block_t rk, left_q, right_q;
	rctl_t ctl;
	logic accept, copy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0; count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
			RegKey0:  key0_q  <= cfg_data;
			RegKey1:  key1_q  <= cfg_data;
			RegKey2:  key2_q  <= cfg_data;
			RegKey3:  key3_q  <= cfg_data;
			RegCount: count_q <= cfg_data;
			default: ;
			endcase
		end
	end

	assign accept = s_axis_tvalid && s_axis_tready;
	assign copy   = accept;

	aeskt_keyexp u_keyexp (
		.clk    (clk),
		.arst_n (arst_n),
		.key    ({key0_q, key1_q, key2_q, key3_q}),
		.start  (accept),
		.done   (kdone),
		.rd_idx (rnd_q),
		.rd_key (rk)
	);

	// round unit control: rk is the registered read at rnd_q, valid in the next cycle
	always_comb begin
		ctl.load = (state_q == ST_LOAD);
		ctl.step = (state_q == ST_RND);
		ctl.last = (rnd_q == rnd_t'(0));   // index wrapped after final key
	end

	// each half holds its high word in the top bits, byte 0 first
	aeskt_round u_round (
		.clk     (clk),
		.ctl     (ctl),
		.rk      (rk),
		.in_l    ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
		.in_r    ({s_axis_tdata[191:128], s_axis_tdata[255:192]}),
		.copy    (copy),
		.left_q  (left_q),
		.right_q (right_q)
	);

	// sequencer: rnd_q is the key index being fetched for the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
			ST_IDLE: begin
				iter_q <= '0;
				if (accept) begin
					state_q <= ST_KEY;
				end
			end
			ST_KEY: begin
				rnd_q <= '0;
				if (kdone) begin
					if (count_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_LOAD;
						rnd_q   <= rnd_t'(1);
					end
				end
			end
			ST_LOAD: begin
				state_q <= ST_RND;
				rnd_q   <= rnd_q + rnd_t'(1);
			end
			ST_RND: begin
				if (rnd_q == rnd_t'(0)) begin
					iter_q <= iter_q + 1'b1;
					if (iter_q + 1'b1 == count_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_LOAD;
						rnd_q   <= rnd_t'(1);
					end
				end else if (rnd_q == rnd_t'(NumRounds)) begin
					rnd_q <= '0;
				end else begin
					rnd_q <= rnd_q + rnd_t'(1);
				end
			end
			ST_OUT: begin
				if (m_axis_tready) begin
					state_q <= ST_IDLE;
				end
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {right_q[63:0], right_q[127:64], left_q[63:0], left_q[127:64]};

`ifndef SYNTH
	// the block never shows a result while taking a request
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready and valid together");
	// a result appears only after enough encryptions
	a_iter: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> iter_q == count_q) else $error("count mismatch");
	// result data holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_iterated_aes256_key_transform_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iterated_aes256_key_transform_top: self-checking bench for the key transform
// Drives 256-bit requests through the stream port and predicts each result with
// a local AES-256 model. Covers a zero count, key and count changes, unknown
// register indexes, then random blocks under random idling on both sides.
// ----------------------------------------------------------------------------

module tb_iterated_aes256_key_transform_top;
	import aeskt_pkg::*;

	localparam int unsigned CycleLimit = 1000000;
	localparam int unsigned MaxShown   = 10;

	// first declared field lands in the top bits, so the last one is tdata[63:0]
	typedef struct packed {
		logic [63:0] right_low;
		logic [63:0] right_high;
		logic [63:0] left_low;
		logic [63:0] left_high;
	} quad_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [255:0]        s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [255:0]        m_axis_tdata;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_idx = '0;
	logic [WordW-1:0]    cfg_data = '0;

	// model copy of the configuration registers
	logic [63:0] key_reg [4];
	logic [63:0] count_reg;

	logic [7:0]   sub_tab [256];
	logic [127:0] sched [15];

	quad_t       pending_results [$];
	int unsigned mismatches = 0;
	longint unsigned cycles = 0;
	bit          sender_idles = 1'b1;
	bit          receiver_stalls = 1'b1;

	iterated_aes256_key_transform_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	// substitution table from the field inverse and the affine map
	task automatic build_sub_tab();
		logic [7:0] inv, s;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++) begin
				if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
			end
			s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
			sub_tab[x] = s;
		end
	endtask

	function automatic logic [31:0] sub4(input logic [31:0] w);
		return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
	endfunction

	task automatic expand_schedule();
		logic [31:0]  w [60];
		logic [255:0] key;
		logic [31:0]  t;
		key = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
		for (int i = 0; i < 8; i++) w[i] = key[255-32*i -: 32];
		for (int i = 8; i < 60; i++) begin
			t = w[i-1];
			if (i % 8 == 0)
				t = sub4({t[23:0], t[31:24]}) ^ {8'h01 << (i/8 - 1), 24'h0};
			else if (i % 8 == 4)
				t = sub4(t);
			w[i] = w[i-8] ^ t;
		end
		for (int r = 0; r < 15; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
	endtask

	function automatic logic [127:0] encrypt(input logic [127:0] blk);
		logic [7:0] s [16];
		logic [7:0] n [16];
		logic [7:0] a0, a1, a2, a3, al;
		for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ sched[0][127-8*i -: 8];
		for (int r = 1; r <= 14; r++) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++) n[i+4*c] = sub_tab[s[i + 4*((c+i) & 3)]];
			if (r != 14) begin
				for (int c = 0; c < 4; c++) begin
					a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
					al = a0 ^ a1 ^ a2 ^ a3;
					n[4*c]   = a0 ^ al ^ gf_mul(a0 ^ a1, 8'h02);
					n[4*c+1] = a1 ^ al ^ gf_mul(a1 ^ a2, 8'h02);
					n[4*c+2] = a2 ^ al ^ gf_mul(a2 ^ a3, 8'h02);
					n[4*c+3] = a3 ^ al ^ gf_mul(a3 ^ a0, 8'h02);
				end
			end
			for (int i = 0; i < 16; i++) s[i] = n[i] ^ sched[r][127-8*i -: 8];
		end
		for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
		return blk;
	endfunction

	task automatic predict_transform(input quad_t req);
		logic [127:0] lb, rb;
		quad_t res;
		expand_schedule();
		lb = {req.left_high, req.left_low};
		rb = {req.right_high, req.right_low};
		for (longint unsigned k = 0; k < count_reg; k++) begin
			lb = encrypt(lb);
			rb = encrypt(rb);
		end
		res.left_high = lb[127:64];  res.left_low = lb[63:0];
		res.right_high = rb[127:64]; res.right_low = rb[63:0];
		pending_results.push_back(res);
	endtask

	// ---------------- drivers ----------------

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
		RegKey0:  key_reg[0] = val;
		RegKey1:  key_reg[1] = val;
		RegKey2:  key_reg[2] = val;
		RegKey3:  key_reg[3] = val;
		RegCount: count_reg = val;
		default: ;
		endcase
	endtask

	task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3);
		write_reg(RegKey0, k0);
		write_reg(RegKey1, k1);
		write_reg(RegKey2, k2);
		write_reg(RegKey3, k3);
	endtask

	// leaves tvalid high so back-to-back requests need no toggle
	task automatic send_request(input quad_t req);
		if (sender_idles && $urandom_range(99) < 21) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= req;
		do @(posedge clk); while (!s_axis_tready);
		predict_transform(req);
	endtask

	// lower the request and wait for every result before touching config
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	function automatic quad_t random_quad();
		quad_t q;
		q.left_high  = {$urandom, $urandom};
		q.left_low   = {$urandom, $urandom};
		q.right_high = {$urandom, $urandom};
		q.right_low  = {$urandom, $urandom};
		return q;
	endfunction

	// ---------------- result checker and stall ----------------

	always @(posedge clk) begin
		quad_t got, want;
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAIL iterated_aes256_key_transform_top");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxShown)
					$display("unexpected result %h at %0t", got, $realtime);
			end else begin
				want = pending_results.pop_front();
				if (got.left_high !== want.left_high || got.left_low !== want.left_low
						|| got.right_high !== want.right_high
						|| got.right_low !== want.right_low) begin
					mismatches++;
					if (mismatches <= MaxShown)
						$display("mismatch at %0t: expected %h actual %h",
							$realtime, want, got);
				end
			end
		end
		m_axis_tready <= receiver_stalls ? ($urandom_range(99) >= 21) : 1'b1;
	end

	// ---------------- tests ----------------

	task automatic test_zero_count();
		quad_t q;
		q = '0;
		send_request(q);
		q = '1;
		send_request(q);
		q.left_high = 64'h0123456789abcdef; q.left_low = 64'hfedcba9876543210;
		q.right_high = 64'h8000000000000001; q.right_low = 64'h5555aaaa5555aaaa;
		send_request(q);
		drain();
	endtask

	task automatic test_standard_vector();
		quad_t q;
		load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f);
		write_reg(RegCount, 64'd1);
		q.left_high = 64'h0011223344556677;  q.left_low = 64'h8899aabbccddeeff;
		q.right_high = 64'h0011223344556677; q.right_low = 64'h8899aabbccddeeff;
		send_request(q);
		send_request('0);
		send_request('1);
		drain();
		write_reg(RegCount, 64'd3);
		send_request(random_quad());
		drain();
	endtask

	task automatic test_key_extremes();
		load_key('1, '1, '1, '1);
		write_reg(RegCount, 64'd2);
		send_request('1);
		send_request(random_quad());
		drain();
		load_key('0, '0, '0, '0);
		send_request('0);
		drain();
	endtask

	// writes to unmapped indexes must leave the key and count alone
	task automatic test_unknown_index();
		write_reg(3'd5, '1);
		write_reg(3'd6, 64'h00000000000000ff);
		write_reg(3'd7, 64'hdeadbeefcafef00d);
		send_request(random_quad());
		drain();
	endtask

	// a key change takes effect on the next request
	task automatic test_key_change();
		write_reg(RegKey2, 64'h0123456789abcdef);
		send_request(random_quad());
		drain();
		write_reg(RegKey0, 64'h8000000000000000);
		send_request(random_quad());
		drain();
	endtask

	task automatic test_long_count();
		write_reg(RegCount, 64'd255);
		send_request(random_quad());
		drain();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 10; ph++) begin
			load_key({$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
			write_reg(RegCount,
				64'((ph == 7) ? $urandom_range(8, 40) : $urandom_range(0, 4)));
			// one phase with no idling at all, one that waits out each result
			sender_idles    = (ph != 3);
			receiver_stalls = (ph != 3);
			for (int n = 0; n < 10; n++) begin
				send_request(random_quad());
				if (ph == 5) drain();
			end
			drain();
		end
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		count_reg = '0;
		build_sub_tab();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_count();
		test_standard_vector();
		test_key_extremes();
		test_unknown_index();
		test_key_change();
		test_long_count();
		test_random();
		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS iterated_aes256_key_transform_top");
		end else begin
			$display("FAIL iterated_aes256_key_transform_top");
		end
		$finish;
	end

endmodule
